### rtl/wbr_pkg.sv
`default_nettype none

package wbr_pkg;

  // Line memory depth and the widths that follow from it
  localparam int MaxWidth = 2048;
  localparam int AddrW    = $clog2(MaxWidth);

  // Configuration port
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = CfgIdxW'(1);
  localparam logic [CfgW-1:0]    FrameWidthRst    = CfgW'(640);
  localparam logic [CfgW-1:0]    FrameHeightRst   = CfgW'(480);
  localparam int MinDim = 2;

  // Width that holds both the width register and the line memory depth
  localparam int WExtW = (AddrW + 1 > CfgW) ? AddrW + 1 : CfgW;

  // Pixel layout: red in the top byte, blue in the bottom byte
  localparam int ChW  = 8;
  localparam int PixW = 3 * ChW;

  // Request kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } wbr_in_t;

  typedef struct packed {
    logic [ChW-1:0] blurred_red;
    logic [ChW-1:0] blurred_green;
    logic [ChW-1:0] blurred_blue;
    logic           frame_done;
  } wbr_out_t;

endpackage

`default_nettype wire

### rtl/wbr_if.sv
`default_nettype none

interface wbr_in_if;
  import wbr_pkg::*;
  logic    valid;
  logic    ready;
  wbr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wbr_out_if;
  import wbr_pkg::*;
  logic     valid;
  logic     ready;
  wbr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/weighted_blur_3x3_rgb_unit.sv
// A result passes S1, S2, S3 and the queue. Throughput: one request per cycle while
// req_i.ready is high, set by the read-modify-write of the two line memories, read at the
// column of a request and, for a pixel, written back in the next cycle. Results leave at one
// per cycle while res_o is ready; a last-column pixel after row 0 gives two, held in an
// 8-entry queue. Reset (rst_ni low, asynchronous) clears counters, window, pipeline and
// queue and restores 640 x 480; the line memories are not cleared and need no clearing pass.
`default_nettype none

module weighted_blur_3x3_rgb_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wbr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wbr_pkg::CfgW-1:0]    cfg_data_i,
  wbr_in_if.sink                     req_i,
  wbr_out_if.source                  res_o
);
  import wbr_pkg::*;

  // Weighted sum of a full window is at most 255 * 15
  localparam int SumW = 12;

  // Division by the weight total as a reciprocal multiply: x * K >> 15.
  // 2185 and 2979 are exact for every sum below 4096; 4096 is a plain shift by 3.
  localparam int RecipW     = 13;
  localparam int RecipShift = 15;
  localparam logic [RecipW-1:0] Recip15     = RecipW'(2185);
  localparam logic [RecipW-1:0] Recip11     = RecipW'(2979);
  localparam logic [RecipW-1:0] RecipCorner = RecipW'(4096);
  localparam int ProdW = SumW + RecipW;
  localparam int QuotW = ProdW - RecipShift;
  localparam logic [ChW-1:0] ChMax = 8'hFF;

  // Weight total codes
  localparam logic [1:0] DEN_FULL   = 2'd0;
  localparam logic [1:0] DEN_EDGE   = 2'd1;
  localparam logic [1:0] DEN_CORNER = 2'd2;

  // Result queue; depth must be a power of two so the pointers wrap on their own
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [2:0][2:0][PixW-1:0] nbhd_t;

  typedef struct packed {
    logic                 valid;
    logic                 done;
    logic [1:0]           den;
    logic [2:0][SumW-1:0] sum;
  } sum_lane_t;

  typedef struct packed {
    logic     valid;
    wbr_out_t res;
  } res_lane_t;

  // Weighted sum of one channel over the rows and columns that lie inside the frame.
  function automatic logic [SumW-1:0] wsum(input nbhd_t nb, input logic [2:0] rv,
                                           input logic [2:0] cv, input int unsigned base);
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
    logic [SumW-1:0] c;
    logic [SumW-1:0] row_sum [3];
    for (int i = 0; i < 3; i++) begin
      a = (rv[i] && cv[0]) ? SumW'(nb[i][0][base +: ChW]) : '0;
      b = (rv[i] && cv[1]) ? SumW'(nb[i][1][base +: ChW]) : '0;
      c = (rv[i] && cv[2]) ? SumW'(nb[i][2][base +: ChW]) : '0;
      if (i == 1) begin
        row_sum[i] = (a << 1) + (b << 1) + b + (c << 1);
      end else begin
        row_sum[i] = a + (b << 1) + c;
      end
    end
    return row_sum[0] + row_sum[1] + row_sum[2];
  endfunction

  // Build one summed lane from a neighborhood and its masks.
  function automatic sum_lane_t make_lane(input logic valid, input logic done, input nbhd_t nb,
                                          input logic [2:0] rv, input logic [2:0] cv);
    sum_lane_t lane;
    lane.valid = valid;
    lane.done  = done;
    if ((&rv) && (&cv)) begin
      lane.den = DEN_FULL;
    end else if ((&rv) || (&cv)) begin
      lane.den = DEN_EDGE;
    end else begin
      lane.den = DEN_CORNER;
    end
    for (int ch = 0; ch < 3; ch++) begin
      lane.sum[ch] = wsum(nb, rv, cv, ch * ChW);
    end
    return lane;
  endfunction

  function automatic logic [ChW-1:0] quot(input logic [SumW-1:0] sum, input logic [1:0] den);
    logic [RecipW-1:0] k;
    logic [ProdW-1:0]  prod;
    logic [QuotW-1:0]  q;
    case (den)
      DEN_FULL:   k = Recip15;
      DEN_EDGE:   k = Recip11;
      DEN_CORNER: k = RecipCorner;
      default:    k = RecipCorner;
    endcase
    prod = ProdW'(sum) * ProdW'(k);
    q    = prod[ProdW-1:RecipShift];
    return (q > QuotW'(ChMax)) ? ChMax : q[ChW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] frame_width_q;
  logic [CfgW-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the width to [2, MaxWidth] and the height to at least 2.
  logic [WExtW-1:0] fw_ext;
  logic [WExtW-1:0] eff_w;
  logic [WExtW-1:0] w_last;
  logic [CfgW-1:0]  eff_h;

  always_comb begin
    fw_ext = WExtW'(frame_width_q);
    if (fw_ext < WExtW'(MinDim)) begin
      eff_w = WExtW'(MinDim);
    end else if (fw_ext > WExtW'(MaxWidth)) begin
      eff_w = WExtW'(MaxWidth);
    end else begin
      eff_w = fw_ext;
    end
    w_last = eff_w - WExtW'(1);
    eff_h  = (frame_height_q < CfgW'(MinDim)) ? CfgW'(MinDim) : frame_height_q;
  end

  // ---------------------------------------------------------------------------
  // Request intake: position counters and result credit
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0]    col_q, col_d;
  logic [CfgW-1:0]     row_q, row_d;
  logic [AddrW-1:0]    drn_q, drn_d;
  logic [FifoCntW-1:0] pending_q, pending_d;

  logic       in_fire;
  logic       is_drain;
  logic       in_frame;
  logic       pix_go;
  logic       drn_go;
  logic       col_last;
  logic       drn_last;
  logic       pix_emit0;
  logic       pix_emit1;
  logic [1:0] n_new;
  logic       pop;

  // Take a request only while the queue can still hold two more results on top of
  // every result already promised to requests in flight.
  assign req_i.ready = (pending_q <= FifoCntW'(FifoDepth - 2));
  assign in_fire     = req_i.valid && req_i.ready;
  assign is_drain    = (req_i.data.kind == KIND_DRAIN);
  assign in_frame    = (row_q < eff_h);

  // Drop pixels once the frame is in, and drain ticks before it is.
  assign pix_go = in_fire && !is_drain && in_frame;
  assign drn_go = in_fire && is_drain && !in_frame;

  assign col_last  = (WExtW'(col_q) >= w_last);
  assign drn_last  = (WExtW'(drn_q) >= w_last);
  assign pix_emit0 = (row_q != '0) && (col_q != '0);
  assign pix_emit1 = (row_q != '0) && col_last;

  always_comb begin
    n_new = 2'd0;
    if (pix_go) begin
      n_new = {1'b0, pix_emit0} + {1'b0, pix_emit1};
    end else if (drn_go) begin
      n_new = 2'd1;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    drn_d = drn_q;
    if (pix_go) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_q + CfgW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end else if (drn_go) begin
      if (drn_last) begin
        drn_d = '0;
        row_d = '0;
        col_d = '0;
      end else begin
        drn_d = drn_q + AddrW'(1);
      end
    end
  end

  assign pending_d = pending_q + FifoCntW'(n_new) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      drn_q     <= '0;
      pending_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      drn_q     <= drn_d;
      pending_q <= pending_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories: older row and newer row, read at one or two columns, written
  // back at the column of the pixel in S1
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] old_mem [MaxWidth];
  logic [PixW-1:0] new_mem [MaxWidth];

  logic             rd_en_a;
  logic             rd_en_b;
  logic [AddrW-1:0] rd_addr_a;
  logic [AddrW-1:0] rd_addr_b;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [PixW-1:0]  wr_old;
  logic [PixW-1:0]  wr_new;

  logic [PixW-1:0] old_a_q;
  logic [PixW-1:0] new_a_q;
  logic [PixW-1:0] old_b_q;
  logic [PixW-1:0] new_b_q;

  // A pixel reads its own column; a drain tick reads its column and the next one.
  // The next column wraps past the top, where it is masked off anyway.
  assign rd_en_a   = pix_go || drn_go;
  assign rd_en_b   = drn_go;
  assign rd_addr_a = pix_go ? col_q : drn_q;
  assign rd_addr_b = drn_q + AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      old_mem[wr_addr] <= wr_old;
    end
    if (rd_en_a) begin
      old_a_q <= old_mem[rd_addr_a];
    end
    if (rd_en_b) begin
      old_b_q <= old_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      new_mem[wr_addr] <= wr_new;
    end
    if (rd_en_a) begin
      new_a_q <= new_mem[rd_addr_a];
    end
    if (rd_en_b) begin
      new_b_q <= new_mem[rd_addr_b];
    end
  end

  // Forward the write of S1 to a read issued in the same cycle at the same column.
  logic            fwd_a_q;
  logic            fwd_b_q;
  logic [PixW-1:0] byp_old_q;
  logic [PixW-1:0] byp_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (rd_en_a) begin
      fwd_a_q <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_q <= wr_en && rd_en_b && (wr_addr == rd_addr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_a) begin
      byp_old_q <= wr_old;
      byp_new_q <= wr_new;
    end
  end

  // ---------------------------------------------------------------------------
  // S1: memory data arrives; shift the window, write back, form and sum the neighborhoods
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_drain_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  s1_px_q;
  logic             s1_emit0_q;
  logic             s1_emit1_q;
  logic             s1_r_ge2_q;
  logic             s1_c_ge1_q;
  logic             s1_c_ge2_q;
  logic             s1_first_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_go || drn_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_go || drn_go) begin
      s1_drain_q <= drn_go;
      s1_addr_q  <= rd_addr_a;
      s1_px_q    <= {req_i.data.red, req_i.data.green, req_i.data.blue};
      s1_emit0_q <= pix_emit0;
      s1_emit1_q <= pix_emit1;
      s1_r_ge2_q <= (row_q >= CfgW'(2));
      s1_c_ge1_q <= (col_q != '0);
      s1_c_ge2_q <= (col_q >= AddrW'(2));
      s1_first_q <= (drn_q == '0);
      s1_last_q  <= drn_last;
    end
  end

  logic [PixW-1:0] old_a;
  logic [PixW-1:0] new_a;
  logic [PixW-1:0] old_b;
  logic [PixW-1:0] new_b;

  assign old_a = fwd_a_q ? byp_old_q : old_a_q;
  assign new_a = fwd_a_q ? byp_new_q : new_a_q;
  assign old_b = fwd_b_q ? byp_old_q : old_b_q;
  assign new_b = fwd_b_q ? byp_new_q : new_b_q;

  // The newer row moves down to the older store; the pixel becomes the newer row.
  assign wr_en   = s1_valid_q && !s1_drain_q;
  assign wr_addr = s1_addr_q;
  assign wr_old  = new_a;
  assign wr_new  = s1_px_q;

  nbhd_t           win_q, win_d;
  logic [PixW-1:0] dprev_old_q;
  logic [PixW-1:0] dprev_new_q;

  always_comb begin
    win_d = win_q;
    if (wr_en) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[0][2] = old_a;
      win_d[1][2] = new_a;
      win_d[2][2] = s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  // Hold the column left of the drain position for the next tick; follow any pixel
  // written to that column in between.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_drain_q) begin
      dprev_old_q <= old_a;
      dprev_new_q <= new_a;
    end else if (wr_en && (wr_addr == drn_q - AddrW'(1))) begin
      dprev_old_q <= wr_old;
      dprev_new_q <= wr_new;
    end
  end

  nbhd_t     nb0;
  nbhd_t     nb1;
  logic      [2:0] rv0, cv0, rv1, cv1;
  logic      lane0_valid;
  logic      lane1_valid;
  logic      lane0_done;
  sum_lane_t s2_d [2];
  sum_lane_t s2_q [2];

  always_comb begin
    nb0 = win_d;
    nb1 = '0;
    for (int i = 0; i < 3; i++) begin
      nb1[i][0] = win_d[i][1];
      nb1[i][1] = win_d[i][2];
    end
    rv0         = {1'b1, 1'b1, s1_r_ge2_q};
    cv0         = {1'b1, 1'b1, s1_c_ge2_q};
    rv1         = {1'b1, 1'b1, s1_r_ge2_q};
    cv1         = {1'b0, 1'b1, s1_c_ge1_q};
    lane0_valid = s1_valid_q && s1_emit0_q;
    lane1_valid = s1_valid_q && s1_emit1_q && !s1_drain_q;
    lane0_done  = 1'b0;
    if (s1_drain_q) begin
      // Last row: the older row above it and the last row itself, no row below.
      nb0         = '0;
      nb0[0][0]   = dprev_old_q;
      nb0[0][1]   = old_a;
      nb0[0][2]   = old_b;
      nb0[1][0]   = dprev_new_q;
      nb0[1][1]   = new_a;
      nb0[1][2]   = new_b;
      rv0         = 3'b011;
      cv0         = {!s1_last_q, 1'b1, !s1_first_q};
      lane0_valid = s1_valid_q;
      lane0_done  = s1_last_q;
    end
    s2_d[0] = make_lane(lane0_valid, lane0_done, nb0, rv0, cv0);
    s2_d[1] = make_lane(lane1_valid, 1'b0, nb1, rv1, cv1);
  end

  // ---------------------------------------------------------------------------
  // S2: divide by the weight total; S3: hand over to the queue
  // ---------------------------------------------------------------------------
  res_lane_t s3_d [2];
  res_lane_t s3_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s3_d[l].valid             = s2_q[l].valid;
      s3_d[l].res.blurred_red   = quot(s2_q[l].sum[2], s2_q[l].den);
      s3_d[l].res.blurred_green = quot(s2_q[l].sum[1], s2_q[l].den);
      s3_d[l].res.blurred_blue  = quot(s2_q[l].sum[0], s2_q[l].den);
      s3_d[l].res.frame_done    = s2_q[l].done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 2; l++) begin
        s2_q[l] <= '0;
        s3_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < 2; l++) begin
        s2_q[l] <= s2_d[l];
        s3_q[l] <= s3_d[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two writes a cycle, lane 0 first; one read a cycle if res_o.ready
  // ---------------------------------------------------------------------------
  wbr_out_t            fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic [FifoPtrW-1:0] wr_slot1;
  logic [1:0]          n_push;

  assign n_push   = {1'b0, s3_q[0].valid} + {1'b0, s3_q[1].valid};
  assign wr_slot1 = wr_ptr_q + FifoPtrW'(s3_q[0].valid);

  always_ff @(posedge clk_i) begin
    if (s3_q[0].valid) begin
      fifo_q[wr_ptr_q] <= s3_q[0].res;
    end
    if (s3_q[1].valid) begin
      fifo_q[wr_slot1] <= s3_q[1].res;
    end
  end

  assign res_o.valid = (cnt_q != '0);
  assign res_o.data  = fifo_q[rd_ptr_q];
  assign pop         = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      cnt_q    <= cnt_q + FifoCntW'(n_push) - FifoCntW'(pop);
    end
  end

endmodule

`default_nettype wire

### tb/weighted_blur_3x3_rgb_unit_tb.sv
`default_nettype none

module weighted_blur_3x3_rgb_unit_tb;
  import wbr_pkg::*;

  // 3x3 neighbourhood of packed pixels, indexed [row][column]
  typedef bit [2:0][2:0][PixW-1:0] nbhd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  wbr_in_if  req_if ();
  wbr_out_if res_if ();

  weighted_blur_3x3_rgb_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Blur predictor state: registers as written, two line memories, the sliding
  // window and the raster counters. Line memories start at zero; entries that
  // were never written only ever land on weights that are masked off.
  // ---------------------------------------------------------------------------
  bit [CfgW-1:0] width_setting  = FrameWidthRst;
  bit [CfgW-1:0] height_setting = FrameHeightRst;
  bit [PixW-1:0] older_line [MaxWidth];
  bit [PixW-1:0] newer_line [MaxWidth];
  nbhd_t         window_px;
  int unsigned   col_idx, row_idx, drain_idx;

  // Blurred pixels still owed by the block, oldest first
  wbr_out_t      blurred_q [$];

  int unsigned   error_count    = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;

  // Clamp the width register to the line memory depth, both registers to two
  function automatic int unsigned active_width();
    if (width_setting < MinDim) return MinDim;
    if (width_setting > MaxWidth) return MaxWidth;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    return (height_setting < MinDim) ? MinDim : height_setting;
  endfunction

  function automatic int unsigned line_slot(input int unsigned col);
    return (col < MaxWidth) ? col : MaxWidth - 1;
  endfunction

  // Weights 1 2 1 / 2 3 2 / 1 2 1 over the neighbours inside the frame, then
  // divide by the weights used (15 inside, 11 on an edge, 8 in a corner)
  function automatic wbr_out_t weighted_average(input nbhd_t nb, input bit [2:0] row_ok,
                                                input bit [2:0] col_ok, input bit done);
    int unsigned sum_r, sum_g, sum_b, den, wt;
    int          i, j;
    wbr_out_t    px;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    den   = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          wt    = (i == 1 && j == 1) ? 3 : ((i == 1 || j == 1) ? 2 : 1);
          den   += wt;
          sum_r += nb[i][j][2*ChW +: ChW] * wt;
          sum_g += nb[i][j][ChW +: ChW] * wt;
          sum_b += nb[i][j][0 +: ChW] * wt;
        end
      end
    end
    px.blurred_red   = ChW'(sum_r / den);
    px.blurred_green = ChW'(sum_g / den);
    px.blurred_blue  = ChW'(sum_b / den);
    px.frame_done    = done;
    return px;
  endfunction

  // Advance the predictor by one accepted request and queue what it yields
  function automatic void compute_blurred(input wbr_in_t item);
    int unsigned   w, h, c, r, d, slot, i;
    bit            last;
    bit [2:0]      row_ok, col_ok;
    bit [PixW-1:0] px;
    nbhd_t         nb;
    w = active_width();
    h = active_height();
    if (item.kind == KIND_PIXEL) begin
      c = col_idx;
      r = row_idx;
      // Pixels that arrive while the last row is flushed are dropped
      if (r >= h) return;
      px   = {item.red, item.green, item.blue};
      slot = line_slot(c);
      for (i = 0; i < 3; i++) begin
        window_px[i][0] = window_px[i][1];
        window_px[i][1] = window_px[i][2];
      end
      window_px[0][2]  = older_line[slot];
      window_px[1][2]  = newer_line[slot];
      window_px[2][2]  = px;
      older_line[slot] = newer_line[slot];
      newer_line[slot] = px;
      last = (c >= w - 1);
      if (r >= 1) begin
        row_ok = {1'b1, 1'b1, r >= 2};
        if (c >= 1) begin
          col_ok = {1'b1, 1'b1, c >= 2};
          blurred_q.push_back(weighted_average(window_px, row_ok, col_ok, 1'b0));
        end
        // The last column has no right neighbour and leaves with its left one
        if (last) begin
          nb = '0;
          for (i = 0; i < 3; i++) begin
            nb[i][0] = window_px[i][1];
            nb[i][1] = window_px[i][2];
          end
          col_ok = {1'b0, 1'b1, c >= 1};
          blurred_q.push_back(weighted_average(nb, row_ok, col_ok, 1'b0));
        end
      end
      if (last) begin
        col_idx = 0;
        row_idx = r + 1;
      end else begin
        col_idx = c + 1;
      end
    end else begin
      d = drain_idx;
      // A drain tick before the last row is complete is dropped
      if (row_idx < h) return;
      last   = (d >= w - 1);
      row_ok = 3'b011;
      col_ok = {d + 1 < w, 1'b1, d >= 1};
      nb     = '0;
      if (col_ok[0]) begin
        nb[0][0] = older_line[line_slot(d - 1)];
        nb[1][0] = newer_line[line_slot(d - 1)];
      end
      nb[0][1] = older_line[line_slot(d)];
      nb[1][1] = newer_line[line_slot(d)];
      if (col_ok[2]) begin
        nb[0][2] = older_line[line_slot(d + 1)];
        nb[1][2] = newer_line[line_slot(d + 1)];
      end
      blurred_q.push_back(weighted_average(nb, row_ok, col_ok, last));
      if (last) begin
        drain_idx = 0;
        row_idx   = 0;
        col_idx   = 0;
      end else begin
        drain_idx = d + 1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Hold valid low for a random gap, then offer the request until accepted.
  // Valid stays high afterwards so back-to-back requests never toggle it.
  task automatic send_request(input wbr_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    compute_blurred(item);
  endtask

  task automatic send_pixel(input logic [ChW-1:0] red, input logic [ChW-1:0] green,
                            input logic [ChW-1:0] blue);
    wbr_in_t item;
    item.kind  = KIND_PIXEL;
    item.red   = red;
    item.green = green;
    item.blue  = blue;
    send_request(item);
  endtask

  task automatic send_random_pixel();
    send_pixel(ChW'($urandom), ChW'($urandom), ChW'($urandom));
  endtask

  // Color bits of a drain tick are don't-care; randomize them anyway
  task automatic send_drain();
    wbr_in_t item;
    item.kind  = KIND_DRAIN;
    item.red   = ChW'($urandom);
    item.green = ChW'($urandom);
    item.blue  = ChW'($urandom);
    send_request(item);
  endtask

  // Drop valid and hold off until every owed pixel is back or the wait gives up, then
  // let quiet_cycles pass so a dropped request cannot still be in flight
  task automatic wait_for_blurred(input int unsigned quiet_cycles);
    int unsigned waited;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (blurred_q.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (quiet_cycles) @(posedge clk_i);
  endtask

  // One write strobe per call; the leading edge keeps strobes from merging
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_setting = CfgW'(value);
    else height_setting = CfgW'(value);
  endtask

  task automatic set_frame(input int unsigned width, input int unsigned height);
    wait_for_blurred(8);
    write_register(CFG_FRAME_WIDTH, width);
    write_register(CFG_FRAME_HEIGHT, height);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted pixel, then pick next cycle's ready
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [ChW-1:0] want,
                                        input logic [ChW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_blurred(input wbr_out_t got);
    wbr_out_t want;
    if (blurred_q.size() == 0) begin
      if (error_count < 100) $error("blurred pixel with no request owing it: %p", got);
      error_count++;
      return;
    end
    want = blurred_q.pop_front();
    compare_field("blurred_red", want.blurred_red, got.blurred_red);
    compare_field("blurred_green", want.blurred_green, got.blurred_green);
    compare_field("blurred_blue", want.blurred_blue, got.blurred_blue);
    compare_field("frame_done", ChW'(want.frame_done), ChW'(got.frame_done));
  endfunction

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) check_blurred(res_if.data);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Three columns by two rows (height register below the minimum) with black,
  // white and alternating bit patterns; a drain tick ahead of the last row and
  // a pixel after it must both be dropped
  task automatic test_small_frame();
    set_frame(3, 0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_drain();
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h0F);
    send_pixel(8'hF0, 8'h33, 8'hCC);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h12, 8'h34, 8'h56);
    repeat (3) send_drain();
  endtask

  // Narrow the frame under a partly sent row, so a column lies past the last
  // one, then narrow it again under the flush so the drain count overshoots
  task automatic test_mid_frame_resize();
    set_frame(4, 2);
    repeat (6) send_random_pixel();
    wait_for_blurred(8);
    write_register(CFG_FRAME_WIDTH, 1);
    send_random_pixel();
    wait_for_blurred(8);
    write_register(CFG_FRAME_WIDTH, 4);
    repeat (2) send_drain();
    wait_for_blurred(8);
    write_register(CFG_FRAME_WIDTH, 0);
    send_drain();
  endtask

  // Width register above the line memory depth: the first row runs past every
  // other test width without closing, then a narrow width ends it
  task automatic test_widest_frame();
    set_frame(4095, 2);
    repeat (96) send_random_pixel();
    wait_for_blurred(8);
    write_register(CFG_FRAME_WIDTH, 2);
    repeat (3) send_random_pixel();
    repeat (2) send_drain();
  endtask

  // Two columns under the largest height the register holds, cut short by a
  // lower height; raise it again under the flush so new pixels overwrite the
  // column left of the drain position before the final tick
  task automatic test_tallest_frame();
    set_frame(2, 4095);
    repeat (12) send_random_pixel();
    wait_for_blurred(8);
    write_register(CFG_FRAME_HEIGHT, 3);
    send_drain();
    wait_for_blurred(8);
    write_register(CFG_FRAME_HEIGHT, 4095);
    repeat (2) send_random_pixel();
    wait_for_blurred(8);
    write_register(CFG_FRAME_HEIGHT, 2);
    send_drain();
  endtask

  // Whole frames of random size and content, sprinkled with requests the
  // block must drop and with pauses until every owed pixel is back
  task automatic test_random_stream(input int unsigned item_goal, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned sent, w, h, r, c, d;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_goal) begin
      // mostly narrow frames, now and then a wider one; 0 and 1 clamp to 2
      if ($urandom_range(7) == 0) set_frame($urandom_range(80, 11), $urandom_range(5, 0));
      else set_frame($urandom_range(10, 0), $urandom_range(5, 0));
      w = active_width();
      h = active_height();
      for (r = 0; r < h; r++) begin
        for (c = 0; c < w; c++) begin
          if ($urandom_range(24) == 0) send_drain();
          if ($urandom_range(63) == 0) wait_for_blurred(0);
          send_random_pixel();
        end
      end
      for (d = 0; d < w; d++) begin
        if ($urandom_range(24) == 0) send_random_pixel();
        send_drain();
      end
      sent += w * h + w;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_small_frame();
    test_mid_frame_resize();
    test_widest_frame();
    test_tallest_frame();
    test_random_stream(300, 0, 0);
    test_random_stream(300, 75, 0);
    test_random_stream(300, 0, 75);
    test_random_stream(300, 8, 8);

    // Let the last results come home, then flag anything still owed
    wait_for_blurred(10);
    if (blurred_q.size() != 0) begin
      $error("%0d blurred pixels never arrived", blurred_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("weighted_blur_3x3_rgb_unit test passed");
    end else begin
      $display("weighted_blur_3x3_rgb_unit test failed");
    end
    $finish;
  end

  // Watchdog: stop the run and report a failure if it hangs
  initial begin
    #5_000_000;
    $display("weighted_blur_3x3_rgb_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/wbr_pkg.sv
rtl/wbr_if.sv
rtl/weighted_blur_3x3_rgb_unit.sv
tb/weighted_blur_3x3_rgb_unit_tb.sv
